>>> rtl/http_request_line_parser_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the HTTP request line parser.
// ----------------------------------------------------------------------------
`ifndef HTTP_REQUEST_LINE_PARSER_CORE_MACROS_SVH
`define HTTP_REQUEST_LINE_PARSER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HRLP_ASSERT_SAME(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("hrlp same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define HRLP_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("hrlp next-cycle check failed");

`endif

>>> rtl/hrlp_pkg.sv
// ----------------------------------------------------------------------------
// hrlp_pkg
// Types, codes and character helpers for the HTTP request line parser.
// ----------------------------------------------------------------------------
`default_nettype none

package hrlp_pkg;

   // Default limits
   localparam int PATH_LIMIT_DEF = 64;
   localparam int ARGS_LIMIT_DEF = 256;

   // Characters
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_LF       = 8'h0A;
   localparam logic [7:0] CH_QUESTION = 8'h3F;
   localparam logic [7:0] CH_PLUS     = 8'h2B;
   localparam logic [7:0] CH_MINUS    = 8'h2D;
   localparam logic [7:0] CH_DOT      = 8'h2E;
   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_NINE     = 8'h39;
   localparam logic [7:0] CH_NUL      = 8'h00;

   // Parser phases
   typedef enum logic [3:0] {
      PH_METHOD   = 4'd0,
      PH_PSKIP    = 4'd1,
      PH_PATH     = 4'd2,
      PH_ARGS     = 4'd3,
      PH_WS       = 4'd4,
      PH_LIT      = 4'd5,
      PH_MAJ_PRE  = 4'd6,
      PH_MAJ_SGN  = 4'd7,
      PH_MAJ_DIG  = 4'd8,
      PH_MIN_PRE  = 4'd9,
      PH_MIN_SGN  = 4'd10,
      PH_MIN_DIG  = 4'd11,
      PH_HALT     = 4'd12
   } phase_type;

   // Result item kinds
   typedef enum logic [1:0] {
      KIND_PATH   = 2'd0,
      KIND_ARGS   = 2'd1,
      KIND_STATUS = 2'd2
   } kind_type;

   // Parse status codes
   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_METHOD = 2'd1,
      ST_BAD    = 2'd2,
      ST_LONG   = 2'd3
   } status_type;

   // Sign flag bit positions
   localparam int SIGN_MAJOR = 0;
   localparam int SIGN_MINOR = 1;

   function automatic logic [7:0] to_lower(input logic [7:0] b);
      return ((b >= 8'h41) && (b <= 8'h5A)) ? (b + 8'd32) : b;
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= CH_ZERO) && (b <= CH_NINE);
   endfunction

   function automatic logic is_num_space(input logic [7:0] b);
      return (b == CH_SPACE) || ((b >= 8'd9) && (b <= 8'd13));
   endfunction

   function automatic logic is_line_ws(input logic [7:0] b);
      return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
   endfunction

   // Lower-case method text "get"
   function automatic logic [7:0] method_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = 8'h67;
         3'd1:    c = 8'h65;
         3'd2:    c = 8'h74;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // Protocol text "HTTP/"
   function automatic logic [7:0] proto_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = 8'h48;
         3'd1:    c = 8'h54;
         3'd2:    c = 8'h54;
         3'd3:    c = 8'h50;
         3'd4:    c = 8'h2F;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // v * 10 + digit, saturating at 255
   function automatic logic [7:0] accumulate(input logic [7:0] v, input logic [7:0] b);
      logic [11:0] n;
      n = ({4'd0, v} << 3) + ({4'd0, v} << 1) + {8'd0, b[3:0]};
      return (n > 12'd255) ? 8'hFF : n[7:0];
   endfunction

   // Version is accepted only as 1.0 or 1.1
   function automatic status_type version_status(input logic [7:0] major,
                                                 input logic [7:0] minor,
                                                 input logic [1:0] sign);
      logic major_ok;
      logic minor_ok;
      major_ok = (major == 8'd1) && !sign[SIGN_MAJOR];
      minor_ok = (minor == 8'd0) || ((minor == 8'd1) && !sign[SIGN_MINOR]);
      return (major_ok && minor_ok) ? ST_OK : ST_BAD;
   endfunction

   // Status when the line text ends in the given phase
   function automatic status_type end_status(input phase_type ph,
                                             input status_type err,
                                             input logic [7:0] major,
                                             input logic [7:0] minor,
                                             input logic [1:0] sign);
      status_type st;
      if (ph == PH_HALT) begin
         st = err;
      end else if (ph == PH_METHOD) begin
         st = ST_METHOD;
      end else if (ph == PH_MIN_DIG) begin
         st = version_status(major, minor, sign);
      end else begin
         st = ST_BAD;
      end
      return st;
   endfunction

endpackage

`default_nettype wire

>>> rtl/http_request_line_parser_core.sv
// An accepted byte passes the input register, then the result register behind rsp_tvalid.
// Throughput: one byte per cycle through input register, parse logic and
// result register; a held result stalls the input register in the same cycle.
// Reset: synchronous, active high; clears both valid flags and the parser
// state to the method phase. No clearing pass is needed.
// ----------------------------------------------------------------------------
// http_request_line_parser_core
// Byte-serial checker for an HTTP request line: emits path and argument
// bytes as they arrive and a status item on the line's final byte.
// ----------------------------------------------------------------------------
`default_nettype none

`include "http_request_line_parser_core_macros.svh"

module http_request_line_parser_core #(
   parameter int PATH_LIMIT = hrlp_pkg::PATH_LIMIT_DEF,
   parameter int ARGS_LIMIT = hrlp_pkg::ARGS_LIMIT_DEF,
   localparam int PATH_W = $clog2(PATH_LIMIT + 1),
   localparam int ARGS_W = $clog2(ARGS_LIMIT + 1),
   localparam int FIELD_W = 8 + 2 + 1 + PATH_W + ARGS_W,
   localparam int DATA_W = ((FIELD_W + 7) / 8) * 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // request line bytes
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [7:0]        req_tdata,   // [7:0] line_byte
   input  wire logic              req_tlast,   // final_byte
   // result items
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [DATA_W-1:0]      rsp_tdata,   // out_byte, parse_status,
                                               // minor_version, path_length,
                                               // args_length, zero pad
   output logic [1:0]             rsp_tuser    // item_kind
);

   localparam logic [PATH_W-1:0] PATH_MAX = PATH_W'(PATH_LIMIT);
   localparam logic [ARGS_W-1:0] ARGS_MAX = ARGS_W'(ARGS_LIMIT);

   // Input register
   logic                 in_valid_ff;
   logic [7:0]           in_byte_ff;
   logic                 in_last_ff;
   logic                 advance;

   // Parser state
   hrlp_pkg::phase_type  phase_ff, phase_in;
   logic [2:0]           lit_idx_ff, lit_idx_in;
   logic [PATH_W-1:0]    path_cnt_ff, path_cnt_in;
   logic [ARGS_W-1:0]    args_cnt_ff, args_cnt_in;
   logic [7:0]           major_ff, major_in;
   logic [7:0]           minor_ff, minor_in;
   logic [1:0]           sign_ff, sign_in;
   hrlp_pkg::status_type err_ff, err_in;

   // Result register
   logic                 rsp_valid_ff;
   hrlp_pkg::kind_type   rsp_kind_ff, rsp_kind_in;
   logic [7:0]           rsp_byte_ff, rsp_byte_in;
   hrlp_pkg::status_type rsp_status_ff, rsp_status_in;
   logic                 rsp_minor_ff, rsp_minor_in;
   logic [PATH_W-1:0]    rsp_path_ff, rsp_path_in;
   logic [ARGS_W-1:0]    rsp_args_ff, rsp_args_in;
   logic                 emit;

   // Move the input stage forward when the result register can take a result
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // Capture incoming byte
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // Parse one byte and form the result
   always_comb begin
      hrlp_pkg::phase_type  eff_ph;
      hrlp_pkg::status_type st;
      logic [7:0]           b;
      b = in_byte_ff;

      phase_in    = phase_ff;
      lit_idx_in  = lit_idx_ff;
      path_cnt_in = path_cnt_ff;
      args_cnt_in = args_cnt_ff;
      major_in    = major_ff;
      minor_in    = minor_ff;
      sign_in     = sign_ff;
      err_in      = err_ff;

      emit          = 1'b0;
      rsp_kind_in   = hrlp_pkg::KIND_PATH;
      rsp_byte_in   = b;
      rsp_status_in = hrlp_pkg::ST_OK;
      rsp_minor_in  = 1'b0;
      eff_ph        = phase_ff;
      st            = hrlp_pkg::ST_OK;

      if (phase_ff == hrlp_pkg::PH_HALT) begin
         // ignore bytes until the line ends
      end else if (b == hrlp_pkg::CH_NUL) begin
         // treat zero byte as the end of the text
         err_in   = hrlp_pkg::end_status(phase_ff, err_ff, major_ff, minor_ff, sign_ff);
         phase_in = hrlp_pkg::PH_HALT;
      end else begin
         // fold skip phases that hand the byte on to the next phase
         if ((eff_ph == hrlp_pkg::PH_PSKIP) && (b != hrlp_pkg::CH_SPACE)) begin
            eff_ph = hrlp_pkg::PH_PATH;
         end
         if ((eff_ph == hrlp_pkg::PH_WS) && !hrlp_pkg::is_line_ws(b)) begin
            eff_ph     = hrlp_pkg::PH_LIT;
            lit_idx_in = 3'd0;
         end
         if (!hrlp_pkg::is_num_space(b) && (b != hrlp_pkg::CH_PLUS) &&
             (b != hrlp_pkg::CH_MINUS)) begin
            if (eff_ph == hrlp_pkg::PH_MAJ_PRE) begin
               eff_ph = hrlp_pkg::PH_MAJ_SGN;
            end else if (eff_ph == hrlp_pkg::PH_MIN_PRE) begin
               eff_ph = hrlp_pkg::PH_MIN_SGN;
            end
         end

         unique case (eff_ph)
            hrlp_pkg::PH_METHOD: begin
               if ((lit_idx_ff > 3'd2) ||
                   (hrlp_pkg::to_lower(b) != hrlp_pkg::method_char(lit_idx_ff))) begin
                  err_in   = hrlp_pkg::ST_METHOD;
                  phase_in = hrlp_pkg::PH_HALT;
               end else begin
                  lit_idx_in = lit_idx_ff + 3'd1;
                  if (lit_idx_ff == 3'd2) begin
                     phase_in = hrlp_pkg::PH_PSKIP;
                  end
               end
            end
            hrlp_pkg::PH_PSKIP, hrlp_pkg::PH_WS: begin
               // skip separator
            end
            hrlp_pkg::PH_PATH: begin
               phase_in = hrlp_pkg::PH_PATH;
               if ((b == hrlp_pkg::CH_SPACE) || (b == hrlp_pkg::CH_QUESTION)) begin
                  if (path_cnt_ff >= PATH_MAX) begin
                     err_in   = hrlp_pkg::ST_LONG;
                     phase_in = hrlp_pkg::PH_HALT;
                  end else if (b == hrlp_pkg::CH_QUESTION) begin
                     phase_in = hrlp_pkg::PH_ARGS;
                  end else begin
                     phase_in = hrlp_pkg::PH_WS;
                  end
               end else if (path_cnt_ff < PATH_MAX) begin
                  path_cnt_in = path_cnt_ff + PATH_W'(1);
                  emit        = 1'b1;
                  rsp_kind_in = hrlp_pkg::KIND_PATH;
               end
            end
            hrlp_pkg::PH_ARGS: begin
               if (b == hrlp_pkg::CH_SPACE) begin
                  phase_in = hrlp_pkg::PH_WS;
               end else if (args_cnt_ff < ARGS_MAX) begin
                  args_cnt_in = args_cnt_ff + ARGS_W'(1);
                  emit        = 1'b1;
                  rsp_kind_in = hrlp_pkg::KIND_ARGS;
               end
            end
            hrlp_pkg::PH_LIT: begin
               if ((lit_idx_in > 3'd4) || (b != hrlp_pkg::proto_char(lit_idx_in))) begin
                  err_in   = hrlp_pkg::ST_BAD;
                  phase_in = hrlp_pkg::PH_HALT;
               end else begin
                  phase_in = (lit_idx_in == 3'd4) ? hrlp_pkg::PH_MAJ_PRE : hrlp_pkg::PH_LIT;
                  lit_idx_in = lit_idx_in + 3'd1;
               end
            end
            hrlp_pkg::PH_MAJ_PRE: begin
               // space stays, sign moves on
               if (b == hrlp_pkg::CH_MINUS) begin
                  sign_in[hrlp_pkg::SIGN_MAJOR] = 1'b1;
               end
               if ((b == hrlp_pkg::CH_PLUS) || (b == hrlp_pkg::CH_MINUS)) begin
                  phase_in = hrlp_pkg::PH_MAJ_SGN;
               end
            end
            hrlp_pkg::PH_MIN_PRE: begin
               if (b == hrlp_pkg::CH_MINUS) begin
                  sign_in[hrlp_pkg::SIGN_MINOR] = 1'b1;
               end
               if ((b == hrlp_pkg::CH_PLUS) || (b == hrlp_pkg::CH_MINUS)) begin
                  phase_in = hrlp_pkg::PH_MIN_SGN;
               end
            end
            hrlp_pkg::PH_MAJ_SGN: begin
               if (!hrlp_pkg::is_digit(b)) begin
                  err_in   = hrlp_pkg::ST_BAD;
                  phase_in = hrlp_pkg::PH_HALT;
               end else begin
                  major_in = hrlp_pkg::accumulate(8'd0, b);
                  phase_in = hrlp_pkg::PH_MAJ_DIG;
               end
            end
            hrlp_pkg::PH_MAJ_DIG: begin
               if (hrlp_pkg::is_digit(b)) begin
                  major_in = hrlp_pkg::accumulate(major_ff, b);
               end else if (b == hrlp_pkg::CH_DOT) begin
                  phase_in = hrlp_pkg::PH_MIN_PRE;
               end else begin
                  err_in   = hrlp_pkg::ST_BAD;
                  phase_in = hrlp_pkg::PH_HALT;
               end
            end
            hrlp_pkg::PH_MIN_SGN: begin
               if (!hrlp_pkg::is_digit(b)) begin
                  err_in   = hrlp_pkg::ST_BAD;
                  phase_in = hrlp_pkg::PH_HALT;
               end else begin
                  minor_in = hrlp_pkg::accumulate(8'd0, b);
                  phase_in = hrlp_pkg::PH_MIN_DIG;
               end
            end
            hrlp_pkg::PH_MIN_DIG: begin
               if (hrlp_pkg::is_digit(b)) begin
                  minor_in = hrlp_pkg::accumulate(minor_ff, b);
               end else begin
                  err_in   = hrlp_pkg::version_status(major_ff, minor_ff, sign_ff);
                  phase_in = hrlp_pkg::PH_HALT;
               end
            end
            default: begin
               // halt is handled above
            end
         endcase
      end

      rsp_path_in = path_cnt_in;
      rsp_args_in = args_cnt_in;

      // Replace any byte item with the status on the final byte, then restart
      if (in_last_ff) begin
         st            = hrlp_pkg::end_status(phase_in, err_in, major_in, minor_in, sign_in);
         emit          = 1'b1;
         rsp_kind_in   = hrlp_pkg::KIND_STATUS;
         rsp_byte_in   = 8'd0;
         rsp_status_in = st;
         rsp_minor_in  = (st == hrlp_pkg::ST_OK) ? minor_in[0] : 1'b0;
         phase_in      = hrlp_pkg::PH_METHOD;
         lit_idx_in    = 3'd0;
         path_cnt_in   = '0;
         args_cnt_in   = '0;
         major_in      = 8'd0;
         minor_in      = 8'd0;
         sign_in       = 2'd0;
         err_in        = hrlp_pkg::ST_OK;
      end
   end

   // Advance parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= hrlp_pkg::PH_METHOD;
         lit_idx_ff  <= 3'd0;
         path_cnt_ff <= '0;
         args_cnt_ff <= '0;
         major_ff    <= 8'd0;
         minor_ff    <= 8'd0;
         sign_ff     <= 2'd0;
         err_ff      <= hrlp_pkg::ST_OK;
      end else if (advance) begin
         phase_ff    <= phase_in;
         lit_idx_ff  <= lit_idx_in;
         path_cnt_ff <= path_cnt_in;
         args_cnt_ff <= args_cnt_in;
         major_ff    <= major_in;
         minor_ff    <= minor_in;
         sign_ff     <= sign_in;
         err_ff      <= err_in;
      end
   end

   // Hold result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance && emit) begin
         rsp_kind_ff   <= rsp_kind_in;
         rsp_byte_ff   <= rsp_byte_in;
         rsp_status_ff <= rsp_status_in;
         rsp_minor_ff  <= rsp_minor_in;
         rsp_path_ff   <= rsp_path_in;
         rsp_args_ff   <= rsp_args_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = DATA_W'({rsp_args_ff, rsp_path_ff, rsp_minor_ff,
                                rsp_status_ff, rsp_byte_ff});

   // Byte items carry no status or version
   `HRLP_ASSERT_SAME(a_byte_item_clean, clock, reset, rsp_valid_ff && (rsp_kind_ff != hrlp_pkg::KIND_STATUS), (rsp_status_ff == hrlp_pkg::ST_OK) && !rsp_minor_ff)
   // Final byte restarts the parser
   `HRLP_ASSERT_NEXT(a_final_restart, clock, reset, advance && in_last_ff, (phase_ff == hrlp_pkg::PH_METHOD) && (path_cnt_ff == '0) && (args_cnt_ff == '0))
   // Final byte always yields a status item
   `HRLP_ASSERT_NEXT(a_final_status, clock, reset, advance && in_last_ff, rsp_valid_ff && (rsp_kind_ff == hrlp_pkg::KIND_STATUS))
   // Counters stay within their limits
   `HRLP_ASSERT_SAME(a_count_limits, clock, reset, 1'b1, (path_cnt_ff <= PATH_MAX) && (args_cnt_ff <= ARGS_MAX))

endmodule

`default_nettype wire
